>>> rtl/btpc_pkg.sv
// Shared types and constants for the barometer temperature/pressure compensation block.
// Calibration record, register indexes and the stage records passed between pipeline parts.
// No dependencies.
package btpc_pkg;

	// Register indexes on the configuration port
	localparam logic [2:0] REG_PRESSURE_SENSITIVITY   = 3'd0;
	localparam logic [2:0] REG_PRESSURE_OFFSET        = 3'd1;
	localparam logic [2:0] REG_SENSITIVITY_TEMP_COEFF = 3'd2;
	localparam logic [2:0] REG_OFFSET_TEMP_COEFF      = 3'd3;
	localparam logic [2:0] REG_REFERENCE_TEMPERATURE  = 3'd4;
	localparam logic [2:0] REG_TEMPERATURE_COEFF      = 3'd5;

	// Six calibration words
	typedef struct packed {
		logic [15:0] pressure_sensitivity;
		logic [15:0] pressure_offset;
		logic [15:0] sensitivity_temp_coeff;
		logic [15:0] offset_temp_coeff;
		logic [15:0] reference_temperature;
		logic [15:0] temperature_coeff;
	} cal_t;

	// First-order results, leaving the front part
	typedef struct packed {
		logic [23:0]        d1;    // raw pressure
		logic signed [37:0] off1;  // first-order offset
		logic signed [36:0] sens1; // first-order sensitivity
		logic signed [18:0] lo;    // first-order temperature minus 2000
		logic [16:0]        t2;    // dT^2 / 2^31
	} front_t;

	// Corrected temperature, offset and sensitivity, leaving the second-order part
	typedef struct packed {
		logic [23:0]        d1;
		logic signed [19:0] temp;
		logic signed [40:0] off;
		logic signed [39:0] sens;
	} second_t;

endpackage

>>> rtl/btpc_front.sv
// First-order compensation: dT, the four calibration products and OFF/SENS/TEMP.
// Three pipeline stages with per-stage valid and bubble-collapsing enables.
// Depends on btpc_pkg.
module btpc_front (
	input  logic            clk,
	input  logic            arst_n,
	input  btpc_pkg::cal_t  cal,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [23:0]     pressure_adc,
	input  logic [23:0]     raw_temperature,
	output logic            out_valid,
	input  logic            out_ready,
	output btpc_pkg::front_t out_data
);
	import btpc_pkg::*;

	logic v_s1, v_s2, v_s3;
	logic en_s1, en_s2, en_s3;

	logic [23:0]        d1_s1, d1_s2;
	logic signed [24:0] dt_s1;
	logic signed [41:0] p_off_s2, p_sens_s2, p_t_s2;
	logic signed [49:0] p_dd_s2;
	front_t             res_s3;

	logic signed [41:0] off_b, sens_b, t_b;
	logic signed [37:0] off1_c;
	logic signed [36:0] sens1_c;

	// A stage moves when it is empty or the next one moves
	assign en_s3    = !v_s3 || out_ready;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	// Stage 1: dT = D2 - C5 * 256
	always_ff @(posedge clk) begin
		if (en_s1) begin
			d1_s1 <= pressure_adc;
			dt_s1 <= $signed({1'b0, raw_temperature})
				- $signed({1'b0, cal.reference_temperature, 8'h00});
		end
	end

	// Stage 2: calibration products
	always_ff @(posedge clk) begin
		if (en_s2) begin
			d1_s2     <= d1_s1;
			p_off_s2  <= $signed({1'b0, cal.offset_temp_coeff}) * dt_s1;
			p_sens_s2 <= $signed({1'b0, cal.sensitivity_temp_coeff}) * dt_s1;
			p_t_s2    <= $signed({1'b0, cal.temperature_coeff}) * dt_s1;
			p_dd_s2   <= dt_s1 * dt_s1;
		end
	end

	// Stage 3: truncating divisions by powers of two, first-order sums
	assign off_b  = p_off_s2 + (p_off_s2[41] ? 42'sd63 : 42'sd0);
	assign sens_b = p_sens_s2 + (p_sens_s2[41] ? 42'sd127 : 42'sd0);
	assign t_b    = p_t_s2 + (p_t_s2[41] ? 42'sd8388607 : 42'sd0);

	assign off1_c  = $signed({5'b0, cal.pressure_offset, 17'b0}) + $signed(off_b[41:6]);
	assign sens1_c = $signed({5'b0, cal.pressure_sensitivity, 16'b0}) + $signed(sens_b[41:7]);

	always_ff @(posedge clk) begin
		if (en_s3) begin
			res_s3.d1    <= d1_s2;
			res_s3.off1  <= off1_c;
			res_s3.sens1 <= sens1_c;
			res_s3.lo    <= t_b[41:23];
			res_s3.t2    <= p_dd_s2[47:31];
		end
	end

	assign out_valid = v_s3;
	assign out_data  = res_s3;

endmodule

>>> rtl/btpc_second.sv
// Second-order low-temperature correction of TEMP, OFF and SENS.
// Three pipeline stages: squares, correction terms, final subtraction.
// Depends on btpc_pkg.
module btpc_second (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  btpc_pkg::front_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output btpc_pkg::second_t out_data
);
	import btpc_pkg::*;

	logic v_s4, v_s5, v_s6;
	logic en_s4, en_s5, en_s6;

	logic signed [18:0] lo;
	logic signed [19:0] vl;
	logic signed [37:0] lo_sq;
	logic signed [39:0] vl_sq;

	logic [23:0]        d1_s4, d1_s5;
	logic signed [37:0] off1_s4, off1_s5;
	logic signed [36:0] sens1_s4, sens1_s5;
	logic signed [19:0] temp_s4, temp_s5;
	logic [35:0]        lo2_s4, vl2_s4;
	logic               cold_s4, vcold_s4;
	logic [39:0]        off2_s5, sens2_s5;
	second_t            res_s6;

	logic [41:0] lo2_61;
	logic [39:0] vl2_15;
	logic [39:0] off2_c, sens2_c;

	assign en_s6    = !v_s6 || out_ready;
	assign en_s5    = !v_s5 || en_s6;
	assign en_s4    = !v_s4 || en_s5;
	assign in_ready = en_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s4) v_s4 <= in_valid;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	// Stage 4: squares of (TEMP-2000) and (TEMP+1500), final temperature
	assign lo    = in_data.lo;
	assign vl    = 20'(lo) + 20'sd3500;
	assign lo_sq = lo * lo;
	assign vl_sq = vl * vl;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			d1_s4    <= in_data.d1;
			off1_s4  <= in_data.off1;
			sens1_s4 <= in_data.sens1;
			lo2_s4   <= lo_sq[35:0];
			vl2_s4   <= vl_sq[35:0];
			cold_s4  <= lo[18];
			vcold_s4 <= (lo < -19'sd3500);
			temp_s4  <= 20'sd2000 + 20'(lo)
				- (lo[18] ? $signed({3'b0, in_data.t2}) : 20'sd0);
		end
	end

	// Stage 5: OFF2 = 61*lo^2/16 (+15*vl^2), SENS2 = 2*lo^2 (+8*vl^2)
	assign lo2_61 = {lo2_s4, 6'b0} - {5'b0, lo2_s4, 1'b0} - {6'b0, lo2_s4};
	assign vl2_15 = {vl2_s4, 4'b0} - {4'b0, vl2_s4};

	always_comb begin
		off2_c  = 40'd0;
		sens2_c = 40'd0;
		if (cold_s4) begin
			off2_c  = {2'b0, lo2_61[41:4]};
			sens2_c = {3'b0, lo2_s4, 1'b0};
			if (vcold_s4) begin
				off2_c  = off2_c + vl2_15;
				sens2_c = sens2_c + {1'b0, vl2_s4, 3'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			d1_s5    <= d1_s4;
			off1_s5  <= off1_s4;
			sens1_s5 <= sens1_s4;
			temp_s5  <= temp_s4;
			off2_s5  <= off2_c;
			sens2_s5 <= sens2_c;
		end
	end

	// Stage 6: corrected offset and sensitivity
	always_ff @(posedge clk) begin
		if (en_s6) begin
			res_s6.d1   <= d1_s5;
			res_s6.temp <= temp_s5;
			res_s6.off  <= {{3{off1_s5[37]}}, off1_s5} - {1'b0, off2_s5};
			res_s6.sens <= {{3{sens1_s5[36]}}, sens1_s5} - sens2_s5;
		end
	end

	assign out_valid = v_s6;
	assign out_data  = res_s6;

endmodule

>>> rtl/btpc_press.sv
// Pressure: ((D1 * SENS) / 2^21 - OFF) / 2^15, with truncation toward zero.
// Four pipeline stages: split product, recombine, first division, final result.
// Depends on btpc_pkg.
module btpc_press (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  btpc_pkg::second_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [31:0]       temperature,
	output logic [31:0]       pressure
);
	import btpc_pkg::*;

	logic v_s7, v_s8, v_s9, v_s10;
	logic en_s7, en_s8, en_s9, en_s10;

	logic signed [39:0] sens;
	logic [43:0]        pp_lo_s7;
	logic signed [44:0] pp_hi_s7;
	logic signed [19:0] temp_s7, temp_s8, temp_s9;
	logic signed [40:0] off_s7, off_s8, off_s9;
	logic [64:0]        x_s8;
	logic [64:0]        x_b;
	logic [43:0]        q1_s9;
	logic [44:0]        y, y_b;
	logic [31:0]        temp_s10, pres_s10;

	assign en_s10   = !v_s10 || out_ready;
	assign en_s9    = !v_s9 || en_s10;
	assign en_s8    = !v_s8 || en_s9;
	assign en_s7    = !v_s7 || en_s8;
	assign in_ready = en_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else begin
			if (en_s7)  v_s7  <= in_valid;
			if (en_s8)  v_s8  <= v_s7;
			if (en_s9)  v_s9  <= v_s8;
			if (en_s10) v_s10 <= v_s9;
		end
	end

	// Stage 7: D1 * SENS as two partial products (low 20 bits, signed upper part)
	assign sens = in_data.sens;

	always_ff @(posedge clk) begin
		if (en_s7) begin
			pp_lo_s7 <= 44'(in_data.d1) * 44'(sens[19:0]);
			pp_hi_s7 <= $signed({1'b0, in_data.d1}) * $signed(sens[39:20]);
			temp_s7  <= in_data.temp;
			off_s7   <= in_data.off;
		end
	end

	// Stage 8: recombine the full product
	always_ff @(posedge clk) begin
		if (en_s8) begin
			x_s8    <= {pp_hi_s7, 20'b0} + {21'b0, pp_lo_s7};
			temp_s8 <= temp_s7;
			off_s8  <= off_s7;
		end
	end

	// Stage 9: divide by 2^21 toward zero
	assign x_b = x_s8 + (x_s8[64] ? 65'h1FFFFF : 65'h0);

	always_ff @(posedge clk) begin
		if (en_s9) begin
			q1_s9   <= x_b[64:21];
			temp_s9 <= temp_s8;
			off_s9  <= off_s8;
		end
	end

	// Stage 10: subtract offset, divide by 2^15 toward zero
	assign y   = {q1_s9[43], q1_s9} - {{4{off_s9[40]}}, off_s9};
	assign y_b = y + (y[44] ? 45'h7FFF : 45'h0);

	always_ff @(posedge clk) begin
		if (en_s10) begin
			temp_s10 <= {{12{temp_s9[19]}}, temp_s9};
			pres_s10 <= {{2{y_b[44]}}, y_b[44:15]};
		end
	end

	assign out_valid   = v_s10;
	assign temperature = temp_s10;
	assign pressure    = pres_s10;

endmodule

>>> rtl/barometer_temp_pressure_compensation.sv
// Barometric sensor compensation with second-order low-temperature correction. Each request
// on the slave side carries one raw 24-bit pressure and one raw 24-bit temperature result;
// the block returns one request on the master side with the temperature in hundredths of a
// degree C and the pressure in hundredths of a millibar, both 32-bit two's complement. The
// datapath is a ten-stage pipeline: a new sample can be taken every clock cycle unless a stall
// on the master side has backed up into the first stage; a stall only holds the stages that
// are full, so bubbles close up. The six calibration words are written through the
// configuration port (index 0 to 5, others ignored); they are to be written only while the
// pipeline is empty, which the user must keep to, as the block itself does not enforce it.
// Files: btpc_pkg, btpc_front, btpc_second, btpc_press.
module barometer_temp_pressure_compensation (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // [23:0] pressure_adc, [47:24] raw_temperature
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [31:0] temperature, [63:32] pressure
	input  logic        cfg_wen,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);
	import btpc_pkg::*;

	cal_t    cal_q;
	logic    f_valid, f_ready, s2_valid, s2_ready;
	front_t  f_data;
	second_t s2_data;
	logic [31:0] temperature, pressure;

	// Calibration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_PRESSURE_SENSITIVITY:   cal_q.pressure_sensitivity   <= cfg_wdata;
				REG_PRESSURE_OFFSET:        cal_q.pressure_offset        <= cfg_wdata;
				REG_SENSITIVITY_TEMP_COEFF: cal_q.sensitivity_temp_coeff <= cfg_wdata;
				REG_OFFSET_TEMP_COEFF:      cal_q.offset_temp_coeff      <= cfg_wdata;
				REG_REFERENCE_TEMPERATURE:  cal_q.reference_temperature  <= cfg_wdata;
				REG_TEMPERATURE_COEFF:      cal_q.temperature_coeff      <= cfg_wdata;
				default: ;
			endcase
		end
	end

	btpc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cal             (cal_q),
		.in_valid        (s_tvalid),
		.in_ready        (s_tready),
		.pressure_adc    (s_tdata[23:0]),
		.raw_temperature (s_tdata[47:24]),
		.out_valid       (f_valid),
		.out_ready       (f_ready),
		.out_data        (f_data)
	);

	btpc_second u_second (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_data   (f_data),
		.out_valid (s2_valid),
		.out_ready (s2_ready),
		.out_data  (s2_data)
	);

	btpc_press u_press (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s2_valid),
		.in_ready    (s2_ready),
		.in_data     (s2_data),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.temperature (temperature),
		.pressure    (pressure)
	);

	assign m_tdata = {pressure, temperature};

endmodule

>>> test/barometer_temp_pressure_compensation_tb.sv
// Self-checking testbench for barometer_temp_pressure_compensation.
// Drives raw pressure/temperature pairs over the stream port and checks each result
// against a local 64-bit compensation model. Depends on btpc_pkg and the block's RTL.
`timescale 1ns / 1ps

module barometer_temp_pressure_compensation_tb;
	import btpc_pkg::*;

	localparam int          CYCLE_LIMIT   = 300000;
	localparam int          DRAIN_CYCLES  = 20;
	localparam logic [2:0]  REG_SPARE_LO  = 3'd6;
	localparam logic [2:0]  REG_SPARE_HI  = 3'd7;
	localparam logic [23:0] RAW_MAX       = 24'hFFFFFF;
	localparam longint      TEMP_SCALE    = 64'sd8388608;
	localparam longint      T2_SCALE      = 64'sd2147483648;

	// One sensor sample; pressure_adc in the low bits as on s_tdata
	typedef struct packed {
		logic [23:0] raw_temperature;
		logic [23:0] pressure_adc;
	} sample_t;

	// One compensated reading; temperature in the low bits as on m_tdata
	typedef struct packed {
		logic signed [31:0] pressure;
		logic signed [31:0] temperature;
	} reading_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [63:0] m_tdata;
	logic        cfg_wen   = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_wdata = '0;

	logic [15:0] cal_copy [6];
	sample_t     pending_samples [$];
	reading_t    expected_readings [$];
	int          samples_in_flight = 0;
	int          fail_count = 0;
	int          cycle_count = 0;
	int          tx_idle_pct = 0;
	int          rx_idle_pct = 0;
	bit          req_taken = 1'b0;

	barometer_temp_pressure_compensation dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // [23:0] pressure_adc, [47:24] raw_temperature
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // [31:0] temperature, [63:32] pressure
		.cfg_wen  (cfg_wen),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// First- and second-order compensation, all in signed 64 bits
	function automatic reading_t compensate(input logic [23:0] raw_p,
		input logic [23:0] raw_t);
		longint d1, d2, c1, c2, c3, c4, c5, c6;
		longint dt, off, sens, temp, pres, lo, vl;
		longint t2, off2, sens2;
		reading_t r;
		d1 = raw_p;
		d2 = raw_t;
		c1 = cal_copy[REG_PRESSURE_SENSITIVITY];
		c2 = cal_copy[REG_PRESSURE_OFFSET];
		c3 = cal_copy[REG_SENSITIVITY_TEMP_COEFF];
		c4 = cal_copy[REG_OFFSET_TEMP_COEFF];
		c5 = cal_copy[REG_REFERENCE_TEMPERATURE];
		c6 = cal_copy[REG_TEMPERATURE_COEFF];
		t2 = 0;
		off2 = 0;
		sens2 = 0;
		dt = d2 - c5 * 256;
		off = c2 * 131072 + (c4 * dt) / 64;
		sens = c1 * 65536 + (c3 * dt) / 128;
		temp = 2000 + (dt * c6) / TEMP_SCALE;
		// cold correction, with an extra term when very cold
		if (temp < 2000) begin
			lo = temp - 2000;
			t2 = (dt * dt) / T2_SCALE;
			off2 = (61 * lo * lo) / 16;
			sens2 = 2 * lo * lo;
			if (temp < -1500) begin
				vl = temp + 1500;
				off2 += 15 * vl * vl;
				sens2 += 8 * vl * vl;
			end
		end
		temp -= t2;
		off -= off2;
		sens -= sens2;
		pres = ((d1 * sens) / 64'sd2097152 - off) / 32768;
		r.temperature = temp[31:0];
		r.pressure = pres[31:0];
		return r;
	endfunction

	// Raw temperature whose first-order result lands near 2000 + rel
	function automatic logic [23:0] raw_temp_near(input longint rel, input int spread);
		longint c5, c6, dt, v;
		int jit;
		c5 = cal_copy[REG_REFERENCE_TEMPERATURE];
		c6 = cal_copy[REG_TEMPERATURE_COEFF];
		if (c6 == 0)
			return 24'($urandom);
		jit = $urandom_range(0, 2 * spread);
		jit -= spread;
		dt = (rel * TEMP_SCALE) / c6;
		v = c5 * 256 + dt + jit;
		if (v < 0)
			v = 0;
		if (v > RAW_MAX)
			v = RAW_MAX;
		return v[23:0];
	endfunction

	function automatic sample_t random_sample();
		sample_t s;
		int r;
		s.pressure_adc = 24'($urandom);
		if ($urandom_range(0, 7) == 0)
			s.pressure_adc = $urandom_range(0, 1) ? RAW_MAX : 24'd0;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: s.raw_temperature = 24'($urandom);
			4, 5:       s.raw_temperature = raw_temp_near(0, 2048);
			6, 7:       s.raw_temperature = raw_temp_near(-3500, 2048);
			8:          s.raw_temperature = $urandom_range(0, 1) ? RAW_MAX : 24'd0;
			default: begin
				r = $urandom_range(0, 33000);
				r -= 25000;
				s.raw_temperature = raw_temp_near(r, 0);
			end
		endcase
		return s;
	endfunction

	function automatic void queue_sample(input logic [23:0] raw_p, input logic [23:0] raw_t);
		sample_t s;
		s.pressure_adc = raw_p;
		s.raw_temperature = raw_t;
		pending_samples.push_back(s);
		samples_in_flight++;
	endfunction

	task automatic write_cal(input logic [2:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		if (idx <= REG_TEMPERATURE_COEFF)
			cal_copy[idx] = val;
	endtask

	// Calibration set per segment: typical, extremes and random
	task automatic load_calibration(input int seg);
		logic [15:0] w [6];
		for (int i = 0; i < 6; i++)
			w[i] = 16'($urandom);
		case (seg)
			0, 8: w = '{16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'd31553, 16'd28165};
			1:    w = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
			2:    w = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000};
			4:    w = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF};
			6:    w = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h8000, 16'h0001};
			default: ;
		endcase
		for (int i = 0; i < 6; i++)
			write_cal(3'(i), w[i]);
		// writes to unused indexes must leave the words alone
		if (seg == 0) begin
			write_cal(REG_SPARE_LO, 16'($urandom));
			write_cal(REG_SPARE_HI, 16'($urandom));
		end
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	// Hold off until every request has been taken and every reading returned
	task automatic wait_drained();
		@(negedge clk);
		while (samples_in_flight != 0 || expected_readings.size() != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	initial begin : stimulus
		int n;
		for (int i = 0; i < 6; i++)
			cal_copy[i] = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		for (int seg = 0; seg < 9; seg++) begin
			case (seg / 3)
				0: begin tx_idle_pct = 19; rx_idle_pct = 66; end
				1: begin tx_idle_pct = 66; rx_idle_pct = 19; end
				default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
			endcase
			load_calibration(seg);
			// directed corners: field extremes, reference point, cold and very cold edges
			if (seg == 0) begin
				queue_sample(24'd0, 24'd0);
				queue_sample(RAW_MAX, RAW_MAX);
				queue_sample(24'd0, RAW_MAX);
				queue_sample(RAW_MAX, 24'd0);
				queue_sample(24'hAAAAAA, 24'h555555);
				queue_sample(24'h555555, 24'hAAAAAA);
				queue_sample(24'h800000, raw_temp_near(0, 0));
				queue_sample(24'h800000, raw_temp_near(-1, 0));
				queue_sample(24'h800000, raw_temp_near(1, 0));
				queue_sample(24'h800000, raw_temp_near(-3500, 0));
				queue_sample(24'h800000, raw_temp_near(-3501, 0));
				queue_sample(24'h800000, raw_temp_near(-3499, 0));
				queue_sample(RAW_MAX, raw_temp_near(-3700, 0));
				queue_sample(24'd1, raw_temp_near(-6000, 0));
				queue_sample(RAW_MAX, raw_temp_near(500, 0));
				queue_sample(24'($urandom), raw_temp_near(-1, 300));
				queue_sample(24'($urandom), raw_temp_near(-3500, 300));
				queue_sample(24'($urandom), raw_temp_near(-20000, 0));
			end
			n = (seg == 0) ? 100 : 135;
			for (int k = 0; k < n / 2; k++)
				pending_samples.push_back(random_sample());
			samples_in_flight += n / 2;
			wait_drained();
			for (int k = n / 2; k < n; k++)
				pending_samples.push_back(random_sample());
			samples_in_flight += n - n / 2;
			wait_drained();
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0 && expected_readings.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Request driver: hold a request until taken, otherwise maybe load the next one
	always @(negedge clk) begin : drive_requests
		sample_t s;
		if (!(s_tvalid && !req_taken)) begin
			if (pending_samples.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
				s = pending_samples.pop_front();
				s_tdata <= s;
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		req_taken = 1'b0;
	end

	// Result-side backpressure
	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	// Monitor: predict on every taken request, check every returned reading
	always @(posedge clk) begin : watch_results
		reading_t got, want;
		cycle_count++;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				expected_readings.push_back(compensate(s_tdata[23:0], s_tdata[47:24]));
				samples_in_flight--;
				req_taken = 1'b1;
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (expected_readings.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected reading: temperature %0d pressure %0d",
							got.temperature, got.pressure);
				end else begin
					want = expected_readings.pop_front();
					if (got.temperature !== want.temperature
						|| got.pressure !== want.pressure) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"reading mismatch: temperature exp %0d got %0d,",
								" pressure exp %0d got %0d"},
								want.temperature, got.temperature,
								want.pressure, got.pressure);
					end
				end
			end
		end
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

endmodule

>>> files.f
rtl/btpc_pkg.sv
rtl/btpc_front.sv
rtl/btpc_second.sv
rtl/btpc_press.sv
rtl/barometer_temp_pressure_compensation.sv
test/barometer_temp_pressure_compensation_tb.sv
